@@ design/bwt_pkg.sv @@
`timescale 1ns / 1ps

package bwt_pkg;

    localparam int ENTRIES_DEFAULT   = 64;
    localparam int ADDR_BITS_DEFAULT = 20;

    // Wide enough for any table index the ENTRIES range allows.
    localparam int IDX_CMP_BITS = 8;

    localparam logic [2:0] REQ_CHECK      = 3'd0;
    localparam logic [2:0] REQ_ADD        = 3'd1;
    localparam logic [2:0] REQ_REMOVE     = 3'd2;
    localparam logic [2:0] REQ_REMOVE_ALL = 3'd3;
    localparam logic [2:0] REQ_ENABLE     = 3'd4;
    localparam logic [2:0] REQ_DISABLE    = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_BADIDX   = 3'd5;

    localparam logic [1:0] KIND_RW     = 2'd0;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic       start;
        logic       step;
        logic       add_we;
        logic       shift;
        logic       en_we;
        logic       en_val;
        logic [1:0] acc_kind;
        logic [5:0] entry_index;
    } cell_ctl_t;

    // Flags carried upwards along the chain.
    typedef struct packed {
        logic found;
        logic dup;
    } up_flags_t;

    // Entry fields other than the address, handed down during a removal.
    typedef struct packed {
        logic [1:0] kind;
        logic       en;
    } entry_meta_t;

endpackage

@@ design/bwt_cell.sv @@
`timescale 1ns / 1ps

module bwt_cell #(
    parameter int ENTRIES    = bwt_pkg::ENTRIES_DEFAULT,
    parameter int ADDR_BITS  = bwt_pkg::ADDR_BITS_DEFAULT,
    parameter int CELL_INDEX = 0,
    localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_BITS  = $clog2(ENTRIES + 1)
) (
    input  logic                  clk,
    input  bwt_pkg::cell_ctl_t    ctl,
    input  logic [ADDR_BITS-1:0]  req_addr,
    input  logic [CNT_BITS-1:0]   count,
    input  bwt_pkg::up_flags_t    up_in,
    output bwt_pkg::up_flags_t    up_out,
    input  logic                  dn_found_in,
    input  logic [IDX_BITS-1:0]   dn_idx_in,
    output logic                  dn_found_out,
    output logic [IDX_BITS-1:0]   dn_idx_out,
    input  logic [ADDR_BITS-1:0]  nb_addr,
    input  bwt_pkg::entry_meta_t  nb_meta,
    output logic [ADDR_BITS-1:0]  entry_addr,
    output bwt_pkg::entry_meta_t  entry_meta
);

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_INDEX);

    logic [ADDR_BITS-1:0] addr_reg;
    bwt_pkg::entry_meta_t meta_reg;
    bwt_pkg::up_flags_t   up_reg, up_next;
    logic                 dn_found_reg, dn_found_next;
    logic [IDX_BITS-1:0]  dn_idx_reg, dn_idx_next;

    logic in_range, addr_eq, hit_local, rm_local, dup_local;
    logic add_here, en_here;
    logic [1:0] store_kind;

    assign in_range  = CNT_BITS'(CELL_INDEX) < count;
    assign addr_eq   = addr_reg == req_addr;
    assign rm_local  = in_range && addr_eq;
    assign dup_local = rm_local && meta_reg.en;
    assign hit_local = dup_local &&
                       (meta_reg.kind == bwt_pkg::KIND_RW || meta_reg.kind == ctl.acc_kind);

    assign add_here   = ctl.add_we && (CNT_BITS'(CELL_INDEX) == count);
    assign en_here    = ctl.en_we &&
                        (bwt_pkg::IDX_CMP_BITS'(ctl.entry_index) ==
                         bwt_pkg::IDX_CMP_BITS'(CELL_INDEX));
    assign store_kind = (ctl.acc_kind == bwt_pkg::KIND_UNUSED) ? bwt_pkg::KIND_RW
                                                               : ctl.acc_kind;

    // The upward chain tells each cell whether an address match lies at or
    // below it; the downward chain keeps the highest hit.
    always_comb
    begin
        up_next.found = up_in.found || rm_local;
        up_next.dup   = up_in.dup || dup_local;
        dn_found_next = dn_found_in || hit_local;
        dn_idx_next   = dn_found_in ? dn_idx_in : (hit_local ? MY_IDX : '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            up_reg       <= '0;
            dn_found_reg <= 1'b0;
            dn_idx_reg   <= '0;
        end
        else if (ctl.step)
        begin
            up_reg       <= up_next;
            dn_found_reg <= dn_found_next;
            dn_idx_reg   <= dn_idx_next;
        end
    end

    // Entry storage. A removal pulls the neighbour above into every cell at
    // or above the removed entry.
    always_ff @(posedge clk)
    begin
        if (add_here)
        begin
            addr_reg      <= req_addr;
            meta_reg.kind <= store_kind;
            meta_reg.en   <= 1'b1;
        end
        else if (ctl.shift && up_reg.found)
        begin
            addr_reg <= nb_addr;
            meta_reg <= nb_meta;
        end
        else if (en_here)
        begin
            meta_reg.en <= ctl.en_val;
        end
    end

    assign up_out       = up_reg;
    assign dn_found_out = dn_found_reg;
    assign dn_idx_out   = dn_idx_reg;
    assign entry_addr   = addr_reg;
    assign entry_meta   = meta_reg;

endmodule

@@ design/breakpoint_watch_table.sv @@
`timescale 1ns / 1ps

// Breakpoint watch table: a packed table of up to ENTRIES breakpoints held in
// a row of cells, one entry per cell, each answering one request per item
// with hit, hit_index, status and the entry count after the request. A check,
// add or remove item runs a scan along the row: every cell compares its entry
// with the request address at once, and the match flags and indices ripple
// one cell per cycle up and down the chain before the result is registered.
// Remove-all, enable, disable and unused request codes need no scan and go
// straight to the final state. A new item is taken in the cycle after the
// previous one has been committed, while its result may still wait in the
// output register, so the block takes no new item until it is through with
// the last; a result still waiting when the next item is ready to commit
// holds that item back until the result is taken. There is no clearing pass
// after reset; entry contents are only read below the entry count.
module breakpoint_watch_table #(
    parameter int ENTRIES   = bwt_pkg::ENTRIES_DEFAULT,
    parameter int ADDR_BITS = bwt_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           req_type,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [1:0]           acc_kind,
    input  logic [5:0]           entry_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic [5:0]           hit_index,
    output logic [2:0]           status,
    output logic [6:0]           count
);

    localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_BITS-1:0]  walk_cnt_reg, walk_cnt_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;

    // Latched request.
    logic [2:0]           req_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [1:0]           kind_reg;
    logic [5:0]           index_reg;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic                 hit_reg, hit_next;
    logic [IDX_BITS-1:0]  hit_idx_reg, hit_idx_next;
    logic [2:0]           status_reg, status_next;

    logic                 accept, slot_free, commit, walk_done, needs_walk;
    bwt_pkg::cell_ctl_t   ctl;

    // Chain: cell i drives index i (i+1 in up_f); the spare end is the tie-off.
    bwt_pkg::up_flags_t   up_f   [ENTRIES+1];
    logic                 dn_f   [ENTRIES+1];
    logic [IDX_BITS-1:0]  dn_idx [ENTRIES+1];
    logic [ADDR_BITS-1:0] e_addr [ENTRIES+1];
    bwt_pkg::entry_meta_t e_meta [ENTRIES+1];

    assign in_ready   = state_reg == S_IDLE;
    assign accept     = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;
    assign walk_done  = walk_cnt_reg == CNT_BITS'(ENTRIES);
    assign commit     = (state_reg == S_FIN) && slot_free;
    assign needs_walk = req_type == bwt_pkg::REQ_CHECK || req_type == bwt_pkg::REQ_ADD ||
                        req_type == bwt_pkg::REQ_REMOVE;

    // Result and table update, decided once the scan has settled. The upward
    // chain's top gives the address-match and duplicate flags; the downward
    // chain's bottom gives the highest hit.
    always_comb
    begin
        ctl             = '0;
        ctl.start       = accept;
        ctl.step        = (state_reg == S_WALK) && !walk_done;
        ctl.acc_kind    = kind_reg;
        ctl.entry_index = index_reg;
        count_next      = count_reg;
        hit_next        = 1'b0;
        hit_idx_next    = '0;
        status_next     = bwt_pkg::ST_OK;

        case (req_reg)
            bwt_pkg::REQ_CHECK:
            begin
                hit_next     = dn_f[0];
                hit_idx_next = dn_idx[0];
            end
            bwt_pkg::REQ_ADD:
            begin
                if (count_reg == CNT_BITS'(ENTRIES))
                    status_next = bwt_pkg::ST_FULL;
                else if (up_f[ENTRIES].dup)
                    status_next = bwt_pkg::ST_DUP;
                else
                begin
                    ctl.add_we = commit;
                    count_next = count_reg + 1'b1;
                end
            end
            bwt_pkg::REQ_REMOVE:
            begin
                if (count_reg == '0)
                    status_next = bwt_pkg::ST_EMPTY;
                else if (!up_f[ENTRIES].found)
                    status_next = bwt_pkg::ST_NOTFOUND;
                else
                begin
                    ctl.shift  = commit;
                    count_next = count_reg - 1'b1;
                end
            end
            bwt_pkg::REQ_REMOVE_ALL:
            begin
                if (count_reg == '0)
                    status_next = bwt_pkg::ST_EMPTY;
                else
                    count_next = '0;
            end
            bwt_pkg::REQ_ENABLE, bwt_pkg::REQ_DISABLE:
            begin
                if ((bwt_pkg::IDX_CMP_BITS + 1)'(index_reg) >=
                    (bwt_pkg::IDX_CMP_BITS + 1)'(count_reg))
                    status_next = bwt_pkg::ST_BADIDX;
                else
                begin
                    ctl.en_we  = commit;
                    ctl.en_val = req_reg == bwt_pkg::REQ_ENABLE;
                end
            end
            default:
            begin
                status_next = bwt_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        walk_cnt_next  = walk_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    walk_cnt_next = '0;
                    state_next    = needs_walk ? S_WALK : S_FIN;
                end
            end
            S_WALK:
            begin
                if (walk_done)
                    state_next = S_FIN;
                else
                    walk_cnt_next = walk_cnt_reg + 1'b1;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            walk_cnt_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_cnt_reg  <= walk_cnt_next;
            out_valid_reg <= out_valid_next;
            if (commit)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            addr_reg  <= addr;
            kind_reg  <= acc_kind;
            index_reg <= entry_index;
        end
        if (commit)
        begin
            hit_reg     <= hit_next;
            hit_idx_reg <= hit_idx_next;
            status_reg  <= status_next;
        end
    end

    assign up_f[0]         = '0;
    assign dn_f[ENTRIES]   = 1'b0;
    assign dn_idx[ENTRIES] = '0;
    assign e_addr[ENTRIES] = '0;
    assign e_meta[ENTRIES] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        bwt_cell #(
            .ENTRIES    (ENTRIES),
            .ADDR_BITS  (ADDR_BITS),
            .CELL_INDEX (i)
        ) u_cell (
            .clk          (clk),
            .ctl          (ctl),
            .req_addr     (addr_reg),
            .count        (count_reg),
            .up_in        (up_f[i]),
            .up_out       (up_f[i+1]),
            .dn_found_in  (dn_f[i+1]),
            .dn_idx_in    (dn_idx[i+1]),
            .dn_found_out (dn_f[i]),
            .dn_idx_out   (dn_idx[i]),
            .nb_addr      (e_addr[i+1]),
            .nb_meta      (e_meta[i+1]),
            .entry_addr   (e_addr[i]),
            .entry_meta   (e_meta[i])
        );
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_index = 6'(hit_idx_reg);
    assign status    = status_reg;
    assign count     = 7'(count_reg);

    // The table never holds more entries than it has cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(ENTRIES))
        else $error("entry count beyond table size");

    // The count moves only when a request is committed.
    a_count_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(count_reg))
        else $error("entry count changed outside a commit");

    // A hit always comes with an ok status.
    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && hit_reg |-> status_reg == bwt_pkg::ST_OK)
        else $error("hit reported with a failing status");

    // A committed hit points at an entry inside the table.
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        commit && hit_next |-> CNT_BITS'(hit_idx_next) < count_reg)
        else $error("hit index outside the table");

    // The scan counter never runs past the length of the row.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        walk_cnt_reg <= CNT_BITS'(ENTRIES))
        else $error("scan counter overran");

endmodule

@@ dv/tb_breakpoint_watch_table.sv @@
`timescale 1ns / 1ps

module tb_breakpoint_watch_table;

    localparam int TABLE_SIZE  = bwt_pkg::ENTRIES_DEFAULT;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 10;

    // Request codes the block ignores, and the access kinds the package leaves out.
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_WRITE   = 2'd2;

    typedef struct packed {
        logic       hit;
        logic [5:0] hit_index;
        logic [2:0] status;
        logic [6:0] count;
    } watch_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  req_type;
    logic [19:0] addr;
    logic [1:0]  acc_kind;
    logic [5:0]  entry_index;
    logic        out_valid;
    logic        out_ready;
    logic        hit;
    logic [5:0]  hit_index;
    logic [2:0]  status;
    logic [6:0]  count;

    // Shadow copy of the breakpoint table, kept in step with accepted items.
    logic [19:0] shadow_addr [TABLE_SIZE];
    logic [1:0]  shadow_kind [TABLE_SIZE];
    logic        shadow_on   [TABLE_SIZE];
    int          shadow_count;

    watch_result_t pending_watch_results [$];

    int   mismatch_count;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_request;
    logic holding;

    breakpoint_watch_table uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .addr        (addr),
        .acc_kind    (acc_kind),
        .entry_index (entry_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .hit_index   (hit_index),
        .status      (status),
        .count       (count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the result of one request and applies it to the shadow table.
    function automatic watch_result_t predict_watch_result(input logic [2:0]  rq,
                                                           input logic [19:0] a,
                                                           input logic [1:0]  k,
                                                           input logic [5:0]  ix);
        watch_result_t r;
        int            i;
        int            pos;
        r.hit       = 1'b0;
        r.hit_index = '0;
        r.status    = bwt_pkg::ST_OK;
        case (rq)
            bwt_pkg::REQ_CHECK:
            begin
                // The highest enabled entry matching address and kind gives the hit.
                for (i = shadow_count - 1; i >= 0; i--)
                begin
                    if (shadow_on[i] && shadow_addr[i] == a &&
                        (shadow_kind[i] == bwt_pkg::KIND_RW || shadow_kind[i] == k))
                    begin
                        r.hit       = 1'b1;
                        r.hit_index = 6'(i);
                        break;
                    end
                end
            end
            bwt_pkg::REQ_ADD:
            begin
                if (shadow_count >= TABLE_SIZE)
                    r.status = bwt_pkg::ST_FULL;
                else
                begin
                    for (i = 0; i < shadow_count; i++)
                        if (shadow_on[i] && shadow_addr[i] == a)
                            r.status = bwt_pkg::ST_DUP;
                    if (r.status == bwt_pkg::ST_OK)
                    begin
                        shadow_addr[shadow_count] = a;
                        shadow_kind[shadow_count] = (k == bwt_pkg::KIND_UNUSED) ?
                                                    bwt_pkg::KIND_RW : k;
                        shadow_on[shadow_count]   = 1'b1;
                        shadow_count++;
                    end
                end
            end
            bwt_pkg::REQ_REMOVE:
            begin
                if (shadow_count == 0)
                    r.status = bwt_pkg::ST_EMPTY;
                else
                begin
                    pos = shadow_count;
                    for (i = shadow_count - 1; i >= 0; i--)
                        if (shadow_addr[i] == a)
                            pos = i;
                    if (pos == shadow_count)
                        r.status = bwt_pkg::ST_NOTFOUND;
                    else
                    begin
                        for (i = pos; i < shadow_count - 1; i++)
                        begin
                            shadow_addr[i] = shadow_addr[i + 1];
                            shadow_kind[i] = shadow_kind[i + 1];
                            shadow_on[i]   = shadow_on[i + 1];
                        end
                        shadow_count--;
                    end
                end
            end
            bwt_pkg::REQ_REMOVE_ALL:
            begin
                if (shadow_count == 0)
                    r.status = bwt_pkg::ST_EMPTY;
                else
                    shadow_count = 0;
            end
            bwt_pkg::REQ_ENABLE, bwt_pkg::REQ_DISABLE:
            begin
                if (int'(ix) >= shadow_count)
                    r.status = bwt_pkg::ST_BADIDX;
                else
                    shadow_on[ix] = (rq == bwt_pkg::REQ_ENABLE);
            end
            default:
            begin
            end
        endcase
        r.count = 7'(shadow_count);
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item was taken.
    task automatic send_item(input logic [2:0]  rq,
                             input logic [19:0] a,
                             input logic [1:0]  k,
                             input logic [5:0]  ix);
        watch_result_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= rq;
        addr        <= a;
        acc_kind    <= k;
        entry_index <= ix;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        want = predict_watch_result(rq, a, k, ix);
        @(negedge clk);
        pending_watch_results.push_back(want);
    endtask

    // The sender stops and waits until every expected result has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_watch_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic check_result();
        watch_result_t want;
        if (pending_watch_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected result: hit=%0b hit_index=%0d status=%0d count=%0d",
                         hit, hit_index, status, count);
        end
        else
        begin
            want = pending_watch_results.pop_front();
            if (hit !== want.hit || hit_index !== want.hit_index ||
                status !== want.status || count !== want.count)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("mismatch: expected hit=%0b hit_index=%0d status=%0d count=%0d",
                             want.hit, want.hit_index, want.status, want.count);
                    $display("          got      hit=%0b hit_index=%0d status=%0d count=%0d",
                             hit, hit_index, status, count);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            check_result();
    end

    // The receiver decides at each falling edge whether it takes a result.
    initial
    begin : result_receiver
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready <= !holding && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // A long hold-off of the receiver, counted here, lets the block fill up.
    initial
    begin : hold_off_counter
        holding = 1'b0;
        forever
        begin
            wait (hold_request);
            @(negedge clk);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            holding <= 1'b0;
            hold_request = 1'b0;
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Requests against an empty table, and the request codes that do nothing.
    task automatic test_empty_table();
        send_item(bwt_pkg::REQ_CHECK,      20'h00000, bwt_pkg::KIND_RW,     6'd0);
        send_item(bwt_pkg::REQ_REMOVE,     20'hFFFFF, bwt_pkg::KIND_RW,     6'd0);
        send_item(bwt_pkg::REQ_REMOVE_ALL, 20'h00000, bwt_pkg::KIND_RW,     6'd0);
        send_item(bwt_pkg::REQ_ENABLE,     20'h00000, bwt_pkg::KIND_RW,     6'd0);
        send_item(bwt_pkg::REQ_DISABLE,    20'hFFFFF, bwt_pkg::KIND_UNUSED, 6'd63);
        send_item(REQ_UNUSED_6,            20'hFFFFF, bwt_pkg::KIND_UNUSED, 6'd63);
        send_item(REQ_UNUSED_7,            20'h00000, bwt_pkg::KIND_RW,     6'd0);
    endtask

    // Adds of every kind, a duplicate of another kind, and kind matching on checks.
    task automatic test_add_and_match();
        send_item(bwt_pkg::REQ_ADD,   20'hFFFFF, bwt_pkg::KIND_RW,     6'd0);
        send_item(bwt_pkg::REQ_ADD,   20'h00000, KIND_READ,            6'd0);
        send_item(bwt_pkg::REQ_ADD,   20'h12345, KIND_WRITE,           6'd0);
        send_item(bwt_pkg::REQ_ADD,   20'hABCDE, bwt_pkg::KIND_UNUSED, 6'd0);
        send_item(bwt_pkg::REQ_ADD,   20'h12345, KIND_READ,            6'd0);
        send_item(bwt_pkg::REQ_CHECK, 20'hFFFFF, KIND_WRITE,           6'd0);
        send_item(bwt_pkg::REQ_CHECK, 20'h00000, KIND_WRITE,           6'd0);
        send_item(bwt_pkg::REQ_CHECK, 20'h00000, KIND_READ,            6'd0);
        send_item(bwt_pkg::REQ_CHECK, 20'h12345, bwt_pkg::KIND_UNUSED, 6'd0);
        send_item(bwt_pkg::REQ_CHECK, 20'hABCDE, bwt_pkg::KIND_UNUSED, 6'd0);
    endtask

    // A disabled entry is no duplicate; removal takes the lowest match and the
    // enable flags travel with the entries as they move down.
    task automatic test_enable_and_shift();
        send_item(bwt_pkg::REQ_DISABLE,    20'h00000, bwt_pkg::KIND_RW, 6'd0);
        send_item(bwt_pkg::REQ_ADD,        20'hFFFFF, KIND_READ,        6'd0);
        send_item(bwt_pkg::REQ_CHECK,      20'hFFFFF, KIND_READ,        6'd0);
        send_item(bwt_pkg::REQ_DISABLE,    20'h00000, bwt_pkg::KIND_RW, 6'd4);
        send_item(bwt_pkg::REQ_CHECK,      20'hFFFFF, bwt_pkg::KIND_RW, 6'd0);
        send_item(bwt_pkg::REQ_ENABLE,     20'h00000, bwt_pkg::KIND_RW, 6'd63);
        send_item(bwt_pkg::REQ_REMOVE,     20'hFFFFF, bwt_pkg::KIND_RW, 6'd0);
        send_item(bwt_pkg::REQ_CHECK,      20'h00000, KIND_READ,        6'd0);
        send_item(bwt_pkg::REQ_ENABLE,     20'h00000, bwt_pkg::KIND_RW, 6'd3);
        send_item(bwt_pkg::REQ_CHECK,      20'hFFFFF, KIND_READ,        6'd0);
        send_item(bwt_pkg::REQ_REMOVE,     20'h55555, bwt_pkg::KIND_RW, 6'd0);
        send_item(bwt_pkg::REQ_REMOVE_ALL, 20'h00000, bwt_pkg::KIND_RW, 6'd0);
    endtask

    // Fill every entry, then try one more add and use the top entry.
    task automatic test_full_table();
        logic [19:0] top_addr;
        top_addr = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            // The low six bits keep the addresses apart.
            top_addr = {14'($urandom), 6'(i)};
            send_item(bwt_pkg::REQ_ADD, top_addr, 2'($urandom), 6'($urandom));
        end
        send_item(bwt_pkg::REQ_ADD,        20'hFFFFF, bwt_pkg::KIND_RW,     6'd0);
        send_item(bwt_pkg::REQ_CHECK,      top_addr,  bwt_pkg::KIND_UNUSED, 6'd0);
        send_item(bwt_pkg::REQ_DISABLE,    20'h00000, bwt_pkg::KIND_RW,     6'd63);
        send_item(bwt_pkg::REQ_ENABLE,     20'h00000, bwt_pkg::KIND_RW,     6'd63);
        send_item(bwt_pkg::REQ_REMOVE_ALL, 20'h00000, bwt_pkg::KIND_RW,     6'd0);
    endtask

    // Random requests drawn mostly from a small address pool so that checks
    // hit, adds collide and removes find their entries.
    task automatic run_random(input int n_items, input int pool_size,
                              input int add_pct, input int clear_pct);
        logic [19:0] pool [$];
        logic [19:0] a;
        logic [2:0]  rq;
        logic [1:0]  k;
        logic [5:0]  ix;
        int          sel;
        pool.push_back(20'h00000);
        pool.push_back(20'hFFFFF);
        while (pool.size() < pool_size)
            pool.push_back(20'($urandom));
        for (int n = 0; n < n_items; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 2)
                rq = $urandom_range(1) ? REQ_UNUSED_7 : REQ_UNUSED_6;
            else if (sel < 2 + clear_pct)
                rq = bwt_pkg::REQ_REMOVE_ALL;
            else if (sel < 2 + clear_pct + add_pct)
                rq = bwt_pkg::REQ_ADD;
            else if (sel < 14 + clear_pct + add_pct)
                rq = bwt_pkg::REQ_REMOVE;
            else if (sel < 21 + clear_pct + add_pct)
                rq = bwt_pkg::REQ_ENABLE;
            else if (sel < 28 + clear_pct + add_pct)
                rq = bwt_pkg::REQ_DISABLE;
            else
                rq = bwt_pkg::REQ_CHECK;
            if ($urandom_range(15) == 0)
                a = 20'($urandom);
            else
                a = pool[$urandom_range(pool.size() - 1)];
            k = 2'($urandom);
            if (shadow_count > 0 && $urandom_range(3) != 0)
                ix = 6'($urandom_range(shadow_count - 1));
            else
                ix = 6'($urandom);
            send_item(rq, a, k, ix);
        end
    endtask

    task automatic test_random_mix();
        run_random(420, 10, 28, 2);
        wait_for_results();
        set_idling(69, 17);
        // A wide pool and no remove-all lets the table run full.
        run_random(420, 96, 40, 0);
        wait_for_results();
        set_idling(0, 0);
        run_random(400, 20, 28, 2);
    endtask

    task automatic test_output_hold_off();
        hold_request = 1'b1;
        run_random(24, 8, 30, 0);
        wait_for_results();
    endtask

    initial
    begin : stimulus
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        req_type       = '0;
        addr           = '0;
        acc_kind       = '0;
        entry_index    = '0;
        hold_request   = 1'b0;
        mismatch_count = 0;
        shadow_count   = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(17, 69);
        test_empty_table();
        test_add_and_match();
        test_enable_and_shift();
        test_full_table();
        wait_for_results();
        test_random_mix();
        test_output_hold_off();

        repeat (TABLE_SIZE + 8) @(posedge clk);
        if (mismatch_count == 0 && pending_watch_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
design/bwt_pkg.sv
design/bwt_cell.sv
design/breakpoint_watch_table.sv
dv/tb_breakpoint_watch_table.sv
